@@ rtl/core/bdpc_pkg.sv @@
// Shared types, constants and defaults of the button debounce and press classifier.
`default_nettype none
package bdpc_pkg;

  localparam int unsigned TimeWidth       = 32;
  localparam int unsigned MsRegWidth      = 16;
  localparam int unsigned PinCount        = 3;
  localparam int unsigned EventWidth      = 2;
  localparam int unsigned CfgIndexWidth   = 2;
  localparam int unsigned CfgDataWidth    = 16;
  localparam int unsigned DefButtonCount  = 3;

  typedef logic [TimeWidth-1:0]  time_ms_t;
  typedef logic [MsRegWidth-1:0] ms_reg_t;
  typedef logic [EventWidth-1:0] btn_event_t;

  localparam btn_event_t EV_NONE    = 2'd0;
  localparam btn_event_t EV_PRESSED = 2'd1;
  localparam btn_event_t EV_SHORT   = 2'd2;
  localparam btn_event_t EV_LONG    = 2'd3;

  localparam logic [CfgIndexWidth-1:0] CFG_DEBOUNCE_MS  = 2'd0;
  localparam logic [CfgIndexWidth-1:0] CFG_HOLD_MS      = 2'd1;
  localparam logic [CfgIndexWidth-1:0] CFG_RELEASE_MASK = 2'd2;
  localparam logic [CfgIndexWidth-1:0] CFG_ACTIVE_LOW   = 2'd3;

  localparam ms_reg_t              RstDebounceMs  = 16'd20;
  localparam ms_reg_t              RstHoldMs      = 16'd1000;
  localparam logic [PinCount-1:0]  RstReleaseMask = 3'b010;
  localparam logic                 RstActiveLow   = 1'b1;

  // Settings every button cell sees.
  typedef struct packed {
    ms_reg_t debounce_ms;
    ms_reg_t hold_ms;
    logic    active_low;
  } btn_cfg_t;

endpackage
`default_nettype wire

@@ rtl/core/bdpc_if.sv @@
// Valid/ready channel interfaces for poll items and event results.
`default_nettype none
interface bdpc_poll_if;
  import bdpc_pkg::*;
  logic                valid;
  logic                ready;
  time_ms_t            now_ms;
  logic [PinCount-1:0] raw_levels;

  modport source (output valid, output now_ms, output raw_levels, input ready);
  modport sink (input valid, input now_ms, input raw_levels, output ready);
endinterface

interface bdpc_event_if;
  import bdpc_pkg::*;
  logic       valid;
  logic       ready;
  btn_event_t button0_event;
  btn_event_t button1_event;
  btn_event_t button2_event;

  modport source (output valid, output button0_event, output button1_event,
                  output button2_event, input ready);
  modport sink (input valid, input button0_event, input button1_event,
                input button2_event, output ready);
endinterface
`default_nettype wire

@@ rtl/core/button_debounce_press_classifier_core.sv @@
// Top level of the button debounce and press classifier.
//
// Each poll transaction carries a millisecond timestamp and the raw pin levels of
// three buttons and yields exactly one result transaction with an event code per
// button. A poll is captured in an input register, all buttons are evaluated side
// by side from that register and the codes land in a result register, so one poll
// is taken every cycle when the result side does not stall. The per-button state
// update, a pair of 32-bit subtract-and-compare paths, is what sets the cycle
// time. Configuration registers may only be written while no poll is in flight.
`default_nettype none
module button_debounce_press_classifier_core #(
  parameter int unsigned BUTTON_COUNT = bdpc_pkg::DefButtonCount
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  bdpc_poll_if.sink                            poll,
  bdpc_event_if.source                         events,
  input  wire logic                            cfg_we,
  input  wire logic [bdpc_pkg::CfgIndexWidth-1:0] cfg_index,
  input  wire logic [bdpc_pkg::CfgDataWidth-1:0]  cfg_data
);
  import bdpc_pkg::*;

  ms_reg_t             debounce_ms;
  ms_reg_t             hold_ms;
  logic [PinCount-1:0] release_mode_mask;
  logic                active_low;
  btn_cfg_t            cfg;

  logic                in_valid;
  time_ms_t            in_now;
  logic [PinCount-1:0] in_levels;

  logic                out_valid;
  btn_event_t          out_ev [PinCount];

  logic                advance;
  btn_event_t          cell_ev [BUTTON_COUNT];
  btn_event_t          field_ev [PinCount];

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ms       <= RstDebounceMs;
      hold_ms           <= RstHoldMs;
      release_mode_mask <= RstReleaseMask;
      active_low        <= RstActiveLow;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DEBOUNCE_MS:  debounce_ms       <= cfg_data;
        CFG_HOLD_MS:      hold_ms           <= cfg_data;
        CFG_RELEASE_MASK: release_mode_mask <= cfg_data[PinCount-1:0];
        CFG_ACTIVE_LOW:   active_low        <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign cfg = '{debounce_ms: debounce_ms, hold_ms: hold_ms, active_low: active_low};

  // The input register moves on whenever the result register is free or being drained.
  assign advance    = in_valid && (!out_valid || events.ready);
  assign poll.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (poll.ready) begin
      in_valid <= poll.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (poll.valid && poll.ready) begin
      in_now    <= poll.now_ms;
      in_levels <= poll.raw_levels;
    end
  end

  for (genvar i = 0; i < BUTTON_COUNT; i++) begin : g_btn
    logic level;
    logic on_release;
    if (i < PinCount) begin : g_pin
      assign level      = in_levels[i];
      assign on_release = release_mode_mask[i];
    end else begin : g_nopin
      // Buttons past the pins see a low pin level and classify on press.
      assign level      = 1'b0;
      assign on_release = 1'b0;
    end
    bdpc_button u_button (
      .clk        (clk),
      .rst        (rst),
      .step       (advance),
      .now_ms     (in_now),
      .level      (level),
      .on_release (on_release),
      .cfg        (cfg),
      .btn_event  (cell_ev[i])
    );
  end

  for (genvar i = 0; i < PinCount; i++) begin : g_field
    if (i < BUTTON_COUNT) begin : g_live
      assign field_ev[i] = cell_ev[i];
    end else begin : g_absent
      assign field_ev[i] = EV_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (events.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_ev <= field_ev;
    end
  end

  assign events.valid         = out_valid;
  assign events.button0_event = out_ev[0];
  assign events.button1_event = out_ev[1];
  assign events.button2_event = out_ev[2];

endmodule
`default_nettype wire

@@ rtl/core/bdpc_button.sv @@
// Debounce and press classification state of a single button.
`default_nettype none
module bdpc_button (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               step,
  input  wire bdpc_pkg::time_ms_t now_ms,
  input  wire logic               level,
  input  wire logic               on_release,
  input  wire bdpc_pkg::btn_cfg_t cfg,
  output bdpc_pkg::btn_event_t    btn_event
);
  import bdpc_pkg::*;

  logic     last_sample;
  logic     stable_level;
  time_ms_t edge_time;
  time_ms_t press_start_time;

  logic     pressed;
  logic     changed;
  time_ms_t edge_time_next;
  time_ms_t since_edge;
  time_ms_t press_len;
  logic     settled;
  logic     take;

  assign pressed        = cfg.active_low ? ~level : level;
  assign changed        = pressed != last_sample;
  assign edge_time_next = changed ? now_ms : edge_time;
  assign since_edge     = now_ms - edge_time_next;
  assign press_len      = now_ms - press_start_time;
  // A fresh change gives zero elapsed time, so only a zero debounce accepts it at once.
  assign settled = since_edge >= {{(TimeWidth-MsRegWidth){1'b0}}, cfg.debounce_ms};
  assign take    = settled && (stable_level != pressed);

  always_comb begin
    btn_event = EV_NONE;
    if (take) begin
      if (pressed) begin
        btn_event = on_release ? EV_NONE : EV_PRESSED;
      end else if (on_release) begin
        btn_event = (press_len >= {{(TimeWidth-MsRegWidth){1'b0}}, cfg.hold_ms})
                    ? EV_LONG : EV_SHORT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_sample      <= 1'b0;
      stable_level     <= 1'b0;
      edge_time        <= '0;
      press_start_time <= '0;
    end else if (step) begin
      last_sample <= pressed;
      edge_time   <= edge_time_next;
      if (take) begin
        stable_level <= pressed;
        if (pressed) begin
          press_start_time <= now_ms;
        end
      end
    end
  end

endmodule
`default_nettype wire

@@ dv/tb.sv @@
// Self-checking testbench for the button debounce and press classifier core.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bdpc_pkg::*;

  typedef logic [PinCount-1:0][EventWidth-1:0] event_set_t;
  typedef enum logic {ROW_POLL, ROW_CFG} row_kind_e;
  typedef struct {
    row_kind_e                kind;
    time_ms_t                 now_ms;
    logic [PinCount-1:0]      levels;
    logic                     typed;
    event_set_t               evs;
    logic [CfgIndexWidth-1:0] idx;
    logic [CfgDataWidth-1:0]  data;
  } stim_row_t;

  localparam int unsigned LongHoldCycles = 200;
  localparam int unsigned PhaseCount     = 8;
  localparam int unsigned PhaseItems     = 56;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                     cfg_we    = 1'b0;
  logic [CfgIndexWidth-1:0] cfg_index = CFG_DEBOUNCE_MS;
  logic [CfgDataWidth-1:0]  cfg_data  = '0;

  bdpc_poll_if  poll_ch();
  bdpc_event_if event_ch();

  button_debounce_press_classifier_core u_top (
    .clk       (clk),
    .rst       (rst),
    .poll      (poll_ch),
    .events    (event_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Shadow of the block's settings and per-button debounce state.
  ms_reg_t             debounce_cfg   = RstDebounceMs;
  ms_reg_t             hold_cfg       = RstHoldMs;
  logic [PinCount-1:0] release_cfg    = RstReleaseMask;
  logic                active_low_cfg = RstActiveLow;
  logic [PinCount-1:0] sample_q = '0;
  logic [PinCount-1:0] stable_q = '0;
  time_ms_t            edge_at [PinCount];
  time_ms_t            press_at [PinCount];

  event_set_t pending_events [$];
  stim_row_t  script [$];
  int unsigned fail_count   = 0;
  int unsigned poll_count   = 0;
  int unsigned result_count = 0;
  int unsigned ev_tally [4];
  bit no_idle       = 1'b0;
  bit sink_hold_req = 1'b0;

  initial begin
    for (int b = 0; b < PinCount; b++) begin
      edge_at[b]  = '0;
      press_at[b] = '0;
    end
    for (int e = 0; e < 4; e++) ev_tally[e] = 0;
  end

  function automatic event_set_t classify_poll(input time_ms_t now_ms,
                                               input logic [PinCount-1:0] levels);
    event_set_t evs;
    logic       pressed;
    time_ms_t   held;
    evs = '0;
    for (int b = 0; b < PinCount; b++) begin
      pressed = active_low_cfg ? ~levels[b] : levels[b];
      if (pressed != sample_q[b]) begin
        sample_q[b] = pressed;
        edge_at[b]  = now_ms;
      end
      held = now_ms - edge_at[b];
      if (held >= time_ms_t'(debounce_cfg) && stable_q[b] != sample_q[b]) begin
        stable_q[b] = sample_q[b];
        if (stable_q[b]) begin
          press_at[b] = now_ms;
          evs[b] = release_cfg[b] ? EV_NONE : EV_PRESSED;
        end else if (release_cfg[b]) begin
          held = now_ms - press_at[b];
          evs[b] = (held >= time_ms_t'(hold_cfg)) ? EV_LONG : EV_SHORT;
        end
      end
    end
    return evs;
  endfunction

  function automatic event_set_t trio(input btn_event_t e0, input btn_event_t e1,
                                      input btn_event_t e2);
    return {e2, e1, e0};
  endfunction

  function automatic stim_row_t row_poll(input time_ms_t now_ms,
                                         input logic [PinCount-1:0] levels);
    return '{ROW_POLL, now_ms, levels, 1'b0, '0, CFG_DEBOUNCE_MS, '0};
  endfunction

  function automatic stim_row_t row_typed(input time_ms_t now_ms,
                                          input logic [PinCount-1:0] levels,
                                          input event_set_t evs);
    return '{ROW_POLL, now_ms, levels, 1'b1, evs, CFG_DEBOUNCE_MS, '0};
  endfunction

  function automatic stim_row_t row_cfg(input logic [CfgIndexWidth-1:0] idx,
                                        input logic [CfgDataWidth-1:0] data);
    return '{ROW_CFG, '0, '0, 1'b0, '0, idx, data};
  endfunction

  task automatic send_poll(input time_ms_t now_ms, input logic [PinCount-1:0] levels,
                           input logic typed, input event_set_t typed_evs);
    event_set_t predicted;
    poll_ch.valid      <= 1'b1;
    poll_ch.now_ms     <= now_ms;
    poll_ch.raw_levels <= levels;
    @(posedge clk);
    while (!poll_ch.ready) @(posedge clk);
    predicted = classify_poll(now_ms, levels);
    pending_events.push_back(typed ? typed_evs : predicted);
    poll_count++;
  endtask

  task automatic sender_gap();
    if (!no_idle && $urandom_range(0, 7) == 0) begin
      poll_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  endtask

  // Every poll yields a result, so an empty queue means the pipeline is empty.
  task automatic wait_idle();
    while (pending_events.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_reg(input logic [CfgIndexWidth-1:0] idx,
                             input logic [CfgDataWidth-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      CFG_DEBOUNCE_MS:  debounce_cfg   = data;
      CFG_HOLD_MS:      hold_cfg       = data;
      CFG_RELEASE_MASK: release_cfg    = data[PinCount-1:0];
      CFG_ACTIVE_LOW:   active_low_cfg = data[0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Result side: random back-pressure plus one long hold-off on request.
  initial begin
    event_ch.ready = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (sink_hold_req) begin
        sink_hold_req = 1'b0;
        event_ch.ready <= 1'b0;
        repeat (LongHoldCycles) @(posedge clk);
        event_ch.ready <= 1'b1;
      end else if (!no_idle && $urandom_range(0, 9) == 0) begin
        event_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
        event_ch.ready <= 1'b1;
      end else begin
        event_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    event_set_t want;
    event_set_t got;
    if (!rst && event_ch.valid && event_ch.ready) begin
      got = {event_ch.button2_event, event_ch.button1_event, event_ch.button0_event};
      for (int b = 0; b < PinCount; b++) ev_tally[got[b]]++;
      if (pending_events.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("ERROR: unexpected result transaction, events %h", got);
      end else begin
        want = pending_events.pop_front();
        for (int b = 0; b < PinCount; b++) begin
          if (got[b] !== want[b]) begin
            fail_count++;
            if (fail_count <= 10)
              $display("ERROR: result %0d button%0d_event expected %0d got %0d",
                       result_count, b, want[b], got[b]);
          end
        end
      end
      result_count++;
    end
  end

  initial begin
    #2_500_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    time_ms_t            now_ms;
    logic [PinCount-1:0] levels;
    int unsigned         step_max;
    logic [15:0]         deb, hold;
    logic [PinCount-1:0] mask;
    logic                pol;

    poll_ch.valid      = 1'b0;
    poll_ch.now_ms     = '0;
    poll_ch.raw_levels = '0;

    // Reset settings: 20 ms debounce, 1000 ms hold, button 1 on release, active low.
    script.push_back(row_typed(32'd0, 3'b111, trio(EV_NONE, EV_NONE, EV_NONE)));
    script.push_back(row_typed(32'd100, 3'b000, trio(EV_NONE, EV_NONE, EV_NONE)));
    script.push_back(row_poll(32'd119, 3'b000));
    script.push_back(row_typed(32'd120, 3'b000, trio(EV_PRESSED, EV_NONE, EV_PRESSED)));
    script.push_back(row_typed(32'd200, 3'b111, trio(EV_NONE, EV_NONE, EV_NONE)));
    script.push_back(row_typed(32'd220, 3'b111, trio(EV_NONE, EV_SHORT, EV_NONE)));
    // Press across the timestamp wrap, then a long release.
    script.push_back(row_typed(32'hFFFF_FF00, 3'b000, trio(EV_NONE, EV_NONE, EV_NONE)));
    script.push_back(row_typed(32'd0, 3'b000, trio(EV_PRESSED, EV_NONE, EV_PRESSED)));
    script.push_back(row_poll(32'd1000, 3'b111));
    script.push_back(row_typed(32'd2000, 3'b111, trio(EV_NONE, EV_LONG, EV_NONE)));
    // Time running backwards, then a short glitch that must be filtered.
    script.push_back(row_poll(32'd500, 3'b000));
    script.push_back(row_poll(32'd100, 3'b000));
    script.push_back(row_poll(32'd110, 3'b101));
    script.push_back(row_poll(32'd112, 3'b000));
    // Zero debounce, zero hold, all on release, active high.
    script.push_back(row_cfg(CFG_DEBOUNCE_MS, 16'd0));
    script.push_back(row_cfg(CFG_HOLD_MS, 16'd0));
    script.push_back(row_cfg(CFG_RELEASE_MASK, 16'hFFFF));
    script.push_back(row_cfg(CFG_ACTIVE_LOW, 16'hFFFE));
    script.push_back(row_typed(32'd50, 3'b111, trio(EV_NONE, EV_NONE, EV_NONE)));
    script.push_back(row_typed(32'd60, 3'b000, trio(EV_LONG, EV_LONG, EV_LONG)));
    script.push_back(row_typed(32'd61, 3'b111, trio(EV_NONE, EV_NONE, EV_NONE)));
    // Largest debounce and hold, all on press.
    script.push_back(row_cfg(CFG_DEBOUNCE_MS, 16'hFFFF));
    script.push_back(row_cfg(CFG_HOLD_MS, 16'hFFFF));
    script.push_back(row_cfg(CFG_RELEASE_MASK, 16'd0));
    script.push_back(row_typed(32'd62, 3'b000, trio(EV_NONE, EV_NONE, EV_NONE)));
    script.push_back(row_poll(32'd65596, 3'b000));
    script.push_back(row_poll(32'd65597, 3'b000));
    script.push_back(row_poll(32'd65600, 3'b111));
    script.push_back(row_typed(32'd131135, 3'b111,
                               trio(EV_PRESSED, EV_PRESSED, EV_PRESSED)));
    script.push_back(row_cfg(CFG_RELEASE_MASK, 16'd7));
    script.push_back(row_poll(32'd131136, 3'b000));
    script.push_back(row_poll(32'd196671, 3'b000));

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (script[r]) begin
      if (script[r].kind == ROW_CFG) begin
        poll_ch.valid <= 1'b0;
        wait_idle();
        program_reg(script[r].idx, script[r].data);
      end else begin
        send_poll(script[r].now_ms, script[r].levels, script[r].typed, script[r].evs);
        sender_gap();
      end
    end
    poll_ch.valid <= 1'b0;

    for (int ph = 0; ph < PhaseCount; ph++) begin
      wait_idle();
      case (ph)
        0: begin deb = 16'd0; hold = 16'd0; mask = 3'b101; pol = 1'b0; end
        1: begin deb = 16'hFFFF; hold = 16'hFFFF; mask = 3'b111; pol = 1'b1; end
        3: begin
          deb  = 16'($urandom_range(0, 65535));
          hold = 16'($urandom_range(0, 65535));
          mask = 3'($urandom_range(0, 7));
          pol  = 1'($urandom_range(0, 1));
        end
        7: begin deb = RstDebounceMs; hold = RstHoldMs; mask = RstReleaseMask;
          pol = RstActiveLow; end
        default: begin
          deb  = 16'($urandom_range(0, 40));
          hold = 16'($urandom_range(0, 300));
          mask = 3'($urandom_range(0, 7));
          pol  = 1'($urandom_range(0, 1));
        end
      endcase
      program_reg(CFG_DEBOUNCE_MS, deb);
      program_reg(CFG_HOLD_MS, hold);
      // Upper bits are junk; only the register's own width must matter.
      program_reg(CFG_RELEASE_MASK, {13'($urandom), mask});
      program_reg(CFG_ACTIVE_LOW, {15'($urandom), pol});

      step_max = (deb + hold / 4) / 4 + 3;
      now_ms   = $urandom;
      levels   = 3'($urandom_range(0, 7));
      if (ph == PhaseCount - 1) no_idle = 1'b1;
      if (ph == 2) sink_hold_req = 1'b1;

      for (int i = 0; i < PhaseItems; i++) begin
        if (ph == 4 && i == PhaseItems / 2) begin
          poll_ch.valid <= 1'b0;
          wait_idle();
        end
        for (int b = 0; b < PinCount; b++)
          if ($urandom_range(0, 5) == 0) levels[b] = ~levels[b];
        if ($urandom_range(0, 9) == 0) levels = 3'($urandom_range(0, 7));
        case ($urandom_range(0, 39))
          0:       now_ms = $urandom;
          1:       now_ms = now_ms - $urandom_range(1, step_max);
          default: now_ms = now_ms + $urandom_range(0, step_max);
        endcase
        send_poll(now_ms, levels, 1'b0, '0);
        // While the result side is held off, keep polls coming back to back.
        if (!(ph == 2 && i < 40)) sender_gap();
      end
      poll_ch.valid <= 1'b0;
    end

    wait_idle();
    repeat (16) @(posedge clk);

    $display("Sent %0d polls over %0d register settings, checked %0d results.",
             poll_count, PhaseCount + 3, result_count);
    $display("Button events seen: none %0d, pressed %0d, short %0d, long %0d.",
             ev_tally[EV_NONE], ev_tally[EV_PRESSED], ev_tally[EV_SHORT],
             ev_tally[EV_LONG]);
    if (fail_count == 0 && pending_events.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
